[src/lbp_pkg.sv]
// Shared types and constants for the LZSS token bit packer.
package lbp_pkg;

	localparam int BYTE_BITS       = 8;
	localparam int LIT_TOKEN_BITS  = 9;
	localparam int MAX_LENGTH_BITS = 8;

	// Input operation codes
	typedef enum logic [1:0] {
		OP_LITERAL = 2'd0,
		OP_PHRASE  = 2'd1,
		OP_FLUSH   = 2'd2
	} op_t;

	// Configuration register indexes
	typedef enum logic {
		CFG_WINDOW_BITS = 1'b0,
		CFG_LENGTH_BITS = 1'b1
	} cfg_idx_t;

	localparam logic [4:0] WINDOW_BITS_RST = 5'd8;
	localparam logic [3:0] LENGTH_BITS_RST = 4'd4;

endpackage

[src/lzss_token_bit_packer_unit.sv]
// Top level of the LZSS token bit packer.
//
//  channel   direction  handshake              payload
//  cfg       in         cfg_we                 cfg_index, cfg_data
//  in        in         in_valid / in_ready    op, char_value, distance, length_code
//  out       out        out_valid / out_ready  out_byte, last
//
// An input transaction is registered, packed in one pass and loaded into the
// output buffer, which sends one byte per cycle while out_ready is high. A token
// yields 0 to (16 + MAX_WINDOW_BITS) / 8 bytes. The input register takes a new
// transaction as its held one moves into the output buffer, which happens while
// the buffer's last byte is being taken or when the buffer is empty. Reset clears
// pending bits and valids, and sets the config registers to their reset values.
module lzss_token_bit_packer_unit import lbp_pkg::*; #(
	parameter int MAX_WINDOW_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  char_value,
	input  logic [15:0] distance,
	input  logic [7:0]  length_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last
);

	localparam int MAXB = (7 + LIT_TOKEN_BITS + MAX_WINDOW_BITS) / BYTE_BITS;
	localparam int CW   = $clog2(MAXB + 1);

	logic [4:0]                window_bits_q;
	logic [3:0]                length_bits_q;
	logic                      load_valid;
	logic                      load_ready;
	logic [MAXB*BYTE_BITS-1:0] load_bytes;
	logic [CW-1:0]             load_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_bits_q <= WINDOW_BITS_RST;
			length_bits_q <= LENGTH_BITS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_WINDOW_BITS: window_bits_q <= cfg_data;
				CFG_LENGTH_BITS: length_bits_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	lbp_pack #(
		.MAX_WINDOW_BITS(MAX_WINDOW_BITS),
		.MAXB(MAXB),
		.CW(CW)
	) u_pack (
		.clk(clk),
		.arst_n(arst_n),
		.window_bits(window_bits_q),
		.length_bits(length_bits_q),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.char_value(char_value),
		.distance(distance),
		.length_code(length_code),
		.load_valid(load_valid),
		.load_ready(load_ready),
		.load_bytes(load_bytes),
		.load_count(load_count)
	);

	lbp_emit #(
		.MAXB(MAXB),
		.CW(CW)
	) u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.load_valid(load_valid),
		.load_ready(load_ready),
		.load_bytes(load_bytes),
		.load_count(load_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.last(last)
	);

endmodule

[src/lbp_pack.sv]
// Input stage and token packing logic: holds the pending byte and fill count.
module lbp_pack import lbp_pkg::*; #(
	parameter int MAX_WINDOW_BITS = 16,
	parameter int MAXB = (7 + LIT_TOKEN_BITS + MAX_WINDOW_BITS) / BYTE_BITS,
	parameter int CW = $clog2(MAXB + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [4:0]                  window_bits,
	input  logic [3:0]                  length_bits,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  op,
	input  logic [7:0]                  char_value,
	input  logic [15:0]                 distance,
	input  logic [7:0]                  length_code,
	output logic                        load_valid,
	input  logic                        load_ready,
	output logic [MAXB*BYTE_BITS-1:0]   load_bytes,
	output logic [CW-1:0]               load_count
);

	localparam int VW = (MAXB + 1) * BYTE_BITS;
	localparam int TW = VW - BYTE_BITS;
	localparam int SW = $clog2(VW);

	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [7:0]  char_s1;
	logic [15:0] dist_s1;
	logic [7:0]  len_s1;

	logic [7:0]  pending_q;
	logic [2:0]  fill_q;

	logic [4:0]    w_eff;
	logic [3:0]    l_eff;
	logic [15:0]   dist_m;
	logic [7:0]    len_m;
	logic [SW-1:0] tok_len;
	logic [SW-1:0] sh_dist;
	logic [SW-1:0] sh_len;
	logic [TW-1:0] tok_lj;
	logic [VW-1:0] vec;
	logic [VW-1:0] vec_rest;
	logic [SW-1:0] nbits;
	logic [SW-4:0] nbytes;
	logic [7:0]    pend_nxt;
	logic [2:0]    fill_nxt;
	logic          load_fire;

	assign load_fire  = valid_s1 && load_ready;
	assign in_ready   = !valid_s1 || load_ready;
	assign load_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= op;
			char_s1 <= char_value;
			dist_s1 <= distance;
			len_s1  <= length_code;
		end
	end

	// Clamp the field widths
	always_comb begin
		if ({1'b0, window_bits} > 6'(MAX_WINDOW_BITS)) begin
			w_eff = 5'(MAX_WINDOW_BITS);
		end else if (window_bits == 5'd0) begin
			w_eff = 5'd1;
		end else begin
			w_eff = window_bits;
		end
		if (length_bits > 4'(MAX_LENGTH_BITS)) begin
			l_eff = 4'(MAX_LENGTH_BITS);
		end else begin
			l_eff = length_bits;
		end
	end

	assign dist_m  = dist_s1 & ~(16'hFFFF << w_eff);
	assign len_m   = len_s1 & ~(8'hFF << l_eff);
	assign sh_dist = SW'(TW - 1) - SW'(w_eff);
	assign sh_len  = sh_dist - SW'(l_eff);

	// Build the token left-justified, then place it after the pending bits
	always_comb begin
		if (op_t'(op_s1) == OP_PHRASE) begin
			tok_len = SW'(1) + SW'(w_eff) + SW'(l_eff);
			tok_lj  = (TW'(1) << (TW - 1)) | (TW'(dist_m) << sh_dist)
				| (TW'(len_m) << sh_len);
		end else begin
			tok_len = SW'(LIT_TOKEN_BITS);
			tok_lj  = TW'(char_s1) << (TW - LIT_TOKEN_BITS);
		end
	end

	assign vec      = {pending_q, TW'(0)} | ({tok_lj, 8'b0} >> fill_q);
	assign nbits    = SW'(fill_q) + tok_len;
	assign nbytes   = nbits[SW-1:3];
	assign vec_rest = vec << {nbytes, 3'b000};

	always_comb begin
		load_bytes = vec[VW-1 -: MAXB*BYTE_BITS];
		load_count = '0;
		pend_nxt   = pending_q;
		fill_nxt   = fill_q;
		unique case (op_t'(op_s1))
			OP_LITERAL, OP_PHRASE: begin
				load_count = CW'(nbytes);
				pend_nxt   = vec_rest[VW-1 -: 8];
				fill_nxt   = nbits[2:0];
			end
			OP_FLUSH: begin
				load_bytes = {pending_q, (MAXB*BYTE_BITS-8)'(0)};
				load_count = (fill_q != 3'd0) ? CW'(1) : CW'(0);
				pend_nxt   = 8'd0;
				fill_nxt   = 3'd0;
			end
			default: begin
				load_count = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 8'd0;
			fill_q    <= 3'd0;
		end else if (load_fire) begin
			pending_q <= pend_nxt;
			fill_q    <= fill_nxt;
		end
	end

endmodule

[src/lbp_emit.sv]
// Output byte buffer: shifts out the bytes of one transaction, one per cycle while out_ready is high.
module lbp_emit import lbp_pkg::*; #(
	parameter int MAXB = 4,
	parameter int CW = $clog2(MAXB + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load_valid,
	output logic                      load_ready,
	input  logic [MAXB*BYTE_BITS-1:0] load_bytes,
	input  logic [CW-1:0]             load_count,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                out_byte,
	output logic                      last
);

	logic [MAXB*BYTE_BITS-1:0] buf_q;
	logic [CW-1:0]             rem_q;
	logic                      out_fire;

	assign out_valid  = (rem_q != '0);
	assign out_fire   = out_valid && out_ready;
	assign load_ready = (rem_q == '0) || ((rem_q == CW'(1)) && out_ready);
	assign out_byte   = buf_q[MAXB*BYTE_BITS-1 -: 8];
	assign last       = (rem_q == CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load_valid && load_ready) begin
			rem_q <= load_count;
		end else if (out_fire) begin
			rem_q <= rem_q - CW'(1);
		end
	end

	// Advance to the next byte on each accepted output
	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			buf_q <= load_bytes;
		end else if (out_fire) begin
			buf_q <= buf_q << BYTE_BITS;
		end
	end

endmodule

[tb/tb_lzss_token_bit_packer_unit.sv]
// Testbench for the LZSS token bit packer: random and directed tokens against a bit-level predictor.
`timescale 1ns / 100ps

module tb_lzss_token_bit_packer_unit;
	import lbp_pkg::*;

	localparam int          MAX_WINDOW_BITS = 16;
	localparam logic [1:0]  OP_UNUSED       = 2'd3;
	localparam int          WATCHDOG_LIMIT  = 2000;
	localparam int          SETTLE_CYCLES   = 16;
	localparam int          PHASE_COUNT     = 9;
	localparam int          PHASE_ITEMS     = 40;

	typedef struct packed {
		logic [7:0] out_val;
		logic       last;
	} packed_byte_t;

	// Predicts the byte stream and checks every output transaction against it.
	class byte_stream_scoreboard;
		logic [4:0]   window_bits;
		logic [3:0]   length_bits;
		logic [7:0]   held_byte;
		logic [2:0]   held_count;
		packed_byte_t expected_bytes[$];
		int           mismatches;

		function new();
			window_bits = WINDOW_BITS_RST;
			length_bits = LENGTH_BITS_RST;
			held_byte   = '0;
			held_count  = '0;
			mismatches  = 0;
		endfunction

		function void configure(cfg_idx_t idx, logic [4:0] val);
			if (idx == CFG_WINDOW_BITS) begin
				window_bits = val;
			end else begin
				length_bits = val[3:0];
			end
		endfunction

		function logic [63:0] low_bits(int unsigned n);
			return (64'd1 << n) - 64'd1;
		endfunction

		// Append a token after the held bits and queue every byte that fills up.
		function void push_token(logic [63:0] token, int unsigned nbits);
			logic [63:0]  acc;
			int unsigned  total;
			int unsigned  emitted;
			packed_byte_t entry;
			acc = ((64'(held_byte) >> (BYTE_BITS - int'(held_count))) << nbits)
				| (token & low_bits(nbits));
			total = int'(held_count) + nbits;
			emitted = 0;
			while (total >= BYTE_BITS) begin
				entry.out_val = 8'(acc >> (total - BYTE_BITS));
				entry.last    = 1'b0;
				expected_bytes.push_back(entry);
				emitted++;
				total -= BYTE_BITS;
			end
			if (emitted > 0)
				expected_bytes[expected_bytes.size() - 1].last = 1'b1;
			held_byte  = 8'((acc & low_bits(total)) << (BYTE_BITS - total));
			held_count = 3'(total);
		endfunction

		function void note_input(logic [1:0] op_code, logic [7:0] ch, logic [15:0] dist_val,
				logic [7:0] len_code);
			int unsigned  w;
			int unsigned  l;
			logic [63:0]  token;
			packed_byte_t entry;
			case (op_code)
				OP_LITERAL: begin
					push_token(64'(ch), LIT_TOKEN_BITS);
				end
				OP_PHRASE: begin
					w = window_bits;
					l = length_bits;
					if (w > MAX_WINDOW_BITS) w = MAX_WINDOW_BITS;
					if (w == 0) w = 1;
					if (l > MAX_LENGTH_BITS) l = MAX_LENGTH_BITS;
					token = (64'd1 << (w + l)) | ((64'(dist_val) & low_bits(w)) << l)
						| (64'(len_code) & low_bits(l));
					push_token(token, 1 + w + l);
				end
				OP_FLUSH: begin
					if (held_count != 0) begin
						entry.out_val = held_byte;
						entry.last    = 1'b1;
						expected_bytes.push_back(entry);
						held_byte  = '0;
						held_count = '0;
					end
				end
				default: begin
				end
			endcase
		endfunction

		function void check_output(logic [7:0] got_val, logic got_last);
			packed_byte_t want;
			if (expected_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output byte %h last %b", got_val, got_last);
			end else begin
				want = expected_bytes.pop_front();
				if (want.out_val !== got_val || want.last !== got_last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected byte %h last %b, got byte %h last %b",
							want.out_val, want.last, got_val, got_last);
				end
			end
		endfunction

		function int outstanding();
			return expected_bytes.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        cfg_we      = 1'b0;
	logic        cfg_index   = 1'b0;
	logic [4:0]  cfg_data    = '0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [1:0]  op          = '0;
	logic [7:0]  char_value  = '0;
	logic [15:0] distance    = '0;
	logic [7:0]  length_code = '0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [7:0]  out_byte;
	logic        last;

	logic        steady      = 1'b0;
	int          idle_cycles = 0;

	byte_stream_scoreboard sb = new();

	lzss_token_bit_packer_unit #(
		.MAX_WINDOW_BITS(MAX_WINDOW_BITS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.char_value (char_value),
		.distance   (distance),
		.length_code(length_code),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Output side: check each transaction, stall at random.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				sb.check_output(out_byte, last);
			out_ready <= steady || ($urandom_range(99) >= 8);
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_lzss_token_bit_packer_unit NOT OK");
				$finish;
			end
		end
	end

	// Hold valid until accepted; valid stays high for a follow-on item.
	task send_item(input logic [1:0] o, input logic [7:0] ch, input logic [15:0] dist_val,
			input logic [7:0] len_code);
		if (!steady && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 30);
		end
		in_valid    <= 1'b1;
		op          <= o;
		char_value  <= ch;
		distance    <= dist_val;
		length_code <= len_code;
		do @(posedge clk); while (!in_ready);
		sb.note_input(o, ch, dist_val, len_code);
	endtask

	task send_random_item();
		int unsigned pick;
		logic [1:0]  o;
		pick = $urandom_range(99);
		if (pick < 45)
			o = OP_LITERAL;
		else if (pick < 85)
			o = OP_PHRASE;
		else if (pick < 95)
			o = OP_FLUSH;
		else
			o = OP_UNUSED;
		send_item(o, 8'($urandom_range(255)), 16'($urandom_range(65535)),
			8'($urandom_range(255)));
	endtask

	// Drop valid and wait for every expected byte, then let trailing work settle.
	task drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task set_config(input logic [4:0] wb, input logic [4:0] lb);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_WINDOW_BITS;
		cfg_data  <= wb;
		@(posedge clk);
		sb.configure(CFG_WINDOW_BITS, wb);
		cfg_index <= CFG_LENGTH_BITS;
		cfg_data  <= lb;
		@(posedge clk);
		sb.configure(CFG_LENGTH_BITS, lb);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	logic [4:0] phase_wb [PHASE_COUNT] = '{5'd8, 5'd16, 5'd1, 5'd0, 5'd31, 5'd20, 5'd3, 5'd0, 5'd0};
	logic [4:0] phase_lb [PHASE_COUNT] = '{5'd4, 5'd8, 5'd0, 5'd9, 5'd15, 5'd31, 5'd2, 5'd0, 5'd0};

	initial begin
		logic [4:0] wb;
		logic [4:0] lb;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration: empty flush, unused op, literal extremes, phrase extremes.
		send_item(OP_FLUSH, 8'h00, 16'h0000, 8'h00);
		send_item(OP_UNUSED, 8'hFF, 16'hFFFF, 8'hFF);
		send_item(OP_LITERAL, 8'h00, 16'h0000, 8'h00);
		send_item(OP_LITERAL, 8'hFF, 16'hFFFF, 8'hFF);
		send_item(OP_PHRASE, 8'h00, 16'hFFFF, 8'hFF);
		send_item(OP_PHRASE, 8'hFF, 16'h0000, 8'h00);
		send_item(OP_FLUSH, 8'h00, 16'h0000, 8'h00);
		send_item(OP_FLUSH, 8'h00, 16'h0000, 8'h00);
		drain();

		// Zero window and length: two-bit phrases stay inside the byte.
		set_config(5'd0, 5'd0);
		send_item(OP_PHRASE, 8'h00, 16'h0001, 8'hFF);
		send_item(OP_PHRASE, 8'h00, 16'h0000, 8'h00);
		send_item(OP_PHRASE, 8'h00, 16'hFFFF, 8'hFF);
		send_item(OP_FLUSH, 8'h00, 16'h0000, 8'h00);
		drain();

		// Over-wide window and length, seven bits held: widest phrase gives four bytes.
		set_config(5'd31, 5'd15);
		repeat (7) send_item(OP_LITERAL, 8'($urandom_range(255)), 16'h0000, 8'h00);
		send_item(OP_PHRASE, 8'h00, 16'hFFFF, 8'hFF);
		send_item(OP_FLUSH, 8'h00, 16'h0000, 8'h00);
		drain();

		for (int p = 0; p < PHASE_COUNT; p++) begin
			if (p >= 7) begin
				wb = 5'($urandom_range(31));
				lb = 5'($urandom_range(31));
			end else begin
				wb = phase_wb[p];
				lb = phase_lb[p];
			end
			set_config(wb, lb);
			steady <= (p == 1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// Hold off mid-phase until the output has caught up.
				if (p == 3 && i == PHASE_ITEMS / 2) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (sb.outstanding() != 0) @(posedge clk);
				end
				send_random_item();
			end
			drain();
		end

		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("tb_lzss_token_bit_packer_unit OK");
		else
			$display("tb_lzss_token_bit_packer_unit NOT OK");
		$finish;
	end

endmodule
